FILE: rtl/swap_pkg.sv
// Shared constants and helpers for the sliding-window absolute peak unit.
`default_nettype none

package swap_pkg;

  localparam int WINDOW_DEF = 256;  // default window length in samples
  localparam int SAMPLE_W   = 16;   // signed sample width
  localparam int MAG_W      = 15;   // saturated magnitude width

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [MAG_W-1:0]    mag_t;

  // |s| with the most negative code clamped to the largest positive magnitude
  function automatic mag_t sat_abs(input sample_t s);
    sample_t neg;
    neg = -s;
    if (!s[SAMPLE_W-1]) begin
      return s[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      return {MAG_W{1'b1}};
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  function automatic mag_t mag_max(input mag_t a, input mag_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/swap_mem.sv
// Single-port-write, single-port-read window memory with registered read data.
`default_nettype none

module swap_mem #(
  parameter int Depth = swap_pkg::WINDOW_DEF,
  parameter int Width = swap_pkg::MAG_W
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/swap_ctrl.sv
// Append/scan sequencer: writes the new entry, sweeps the window, holds the peak.
`default_nettype none

module swap_ctrl #(
  parameter int Window = swap_pkg::WINDOW_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request side
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire swap_pkg::sample_t        req_x,
  input  wire swap_pkg::sample_t        req_y,
  input  wire swap_pkg::sample_t        req_z,
  // memory
  output logic                          mem_wr_en,
  output logic [$clog2(Window)-1:0]     mem_wr_addr,
  output swap_pkg::mag_t                mem_wr_data,
  output logic [$clog2(Window)-1:0]     mem_rd_addr,
  input  wire swap_pkg::mag_t           mem_rd_data,
  // result side
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output swap_pkg::mag_t                res_peak
);

  import swap_pkg::*;

  localparam int AW = $clog2(Window);
  localparam int FW = $clog2(Window + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(Window - 1);
  localparam logic [FW-1:0] FULL_CNT  = FW'(Window);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_vld_r, rd_ok_r;
  mag_t          peak_r, peak_nxt;
  logic          res_valid_r, res_valid_nxt;
  mag_t          res_peak_r, res_peak_nxt;
  logic          accept;
  logic          out_free;

  assign req_ready   = (state_r == ST_IDLE);
  assign accept      = req_valid && req_ready;
  assign out_free    = !res_valid_r || res_ready;

  // per-entry max of the three saturated magnitudes; the window peak is the
  // max of these
  assign mem_wr_en   = accept;
  assign mem_wr_addr = slot_r;
  assign mem_wr_data = mag_max(sat_abs(req_x), mag_max(sat_abs(req_y), sat_abs(req_z)));
  assign mem_rd_addr = rd_addr_r;

  assign res_valid   = res_valid_r;
  assign res_peak    = res_peak_r;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    rd_addr_nxt   = rd_addr_r;
    peak_nxt      = peak_r;
    res_valid_nxt = res_valid_r;
    res_peak_nxt  = res_peak_r;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    // entries beyond the fill count were never written and count as zero
    if (rd_vld_r && rd_ok_r && (mem_rd_data > peak_r)) begin
      peak_nxt = mem_rd_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_nxt    = (slot_r == LAST_ADDR) ? '0 : slot_r + 1'b1;
          fill_nxt    = (fill_r == FULL_CNT) ? fill_r : fill_r + 1'b1;
          rd_addr_nxt = '0;
          peak_nxt    = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr_nxt = rd_addr_r + 1'b1;
        if (rd_addr_r == LAST_ADDR) begin
          rd_addr_nxt = '0;
          state_nxt   = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          res_valid_nxt = 1'b1;
          res_peak_nxt  = peak_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      rd_addr_r   <= '0;
      rd_vld_r    <= 1'b0;
      rd_ok_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      rd_addr_r   <= rd_addr_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      rd_ok_r     <= (FW'(rd_addr_r) < fill_r);
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    peak_r     <= peak_nxt;
    res_peak_r <= res_peak_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/sliding_window_abs_peak_unit.sv
// Top level of the sliding-window absolute peak unit for one three-axis sensor.
// Result: out_tvalid rises after the SCAN sweep and DRAIN, once FINISH sees the output free.
// Requests: in_tready is high only in IDLE, so a new request waits until the previous one has
//   passed the one-entry-per-cycle sweep of the window memory read port and handed off its result.
// Reset: rst_n (synchronous, active low) clears the sequencer, write slot and fill
//   count; the memory is not cleared, unwritten entries count as zero via the fill count.
`default_nettype none

module sliding_window_abs_peak_unit #(
  parameter int WINDOW = swap_pkg::WINDOW_DEF  // window length, 2 .. 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [14:0] peak_magnitude, [15] zero
);

  import swap_pkg::*;

  localparam int AW = $clog2(WINDOW);

  sample_t       sample_x, sample_y, sample_z;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  mag_t          mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  mag_t          mem_rd_data;
  mag_t          peak_magnitude;

  // unpack the request fields
  assign sample_x = in_tdata[15:0];
  assign sample_y = in_tdata[31:16];
  assign sample_z = in_tdata[47:32];

  // Sequencer: on accept it stores max(|x|,|y|,|z|) at the write slot, then
  // sweeps every entry through the read port and keeps the running max.
  // The write lands on the accepting edge, before the first read of the sweep, so no forwarding needed.
  swap_ctrl #(
    .Window (WINDOW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_x       (sample_x),
    .req_y       (sample_y),
    .req_z       (sample_z),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_peak    (peak_magnitude)
  );

  // window storage: one saturated magnitude per sample slot
  swap_mem #(
    .Depth (WINDOW),
    .Width (MAG_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_tdata = {1'b0, peak_magnitude};

endmodule

`default_nettype wire
